// ----- hw/rtl/ssim_pkg.sv -----
// ----------------------------------------------------------------------------
// ssim_pkg
// Shared types, widths and codes for the block-mean SSIM quality block.
// ----------------------------------------------------------------------------
package ssim_pkg;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 20;
  localparam int SQ_W   = 28;
  localparam int DIM_W  = 14;
  localparam int BS_W   = 7;
  localparam int CK_W   = 24;
  localparam int CREG_W = 13;
  localparam int MEAN_W = 32;
  localparam int TOT_W  = 56;

  // Divider operand widths: numerators and denominators stay below 2^60.
  localparam int DW     = 61;
  localparam int QW     = 56;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd30;
  localparam logic [STEP_W-1:0] INT_STEPS  = 6'd56;
  localparam logic [QW-1:0]     ONE_Q30    = QW'(64'd1 << 30);

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_BLOCK  = 64;

  localparam int Q_DEPTH = 4;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_BLOCK    = 3'd2;
  localparam logic [2:0] REG_LUMA     = 3'd3;
  localparam logic [2:0] REG_CONTRAST = 3'd4;

  localparam logic [CREG_W-1:0] RST_WIDTH    = 13'd512;
  localparam logic [CREG_W-1:0] RST_HEIGHT   = 13'd512;
  localparam logic [BS_W-1:0]   RST_BLOCK    = 7'd8;
  localparam logic [CK_W-1:0]   RST_LUMA     = 24'd426148;
  localparam logic [CK_W-1:0]   RST_CONTRAST = 24'd3835331;

  // Product slots of the back end's shared multiplier, in issue order.
  localparam int MI_NUM = 12;
  localparam logic [3:0] MI_N    = 4'd0;
  localparam logic [3:0] MI_N2   = 4'd1;
  localparam logic [3:0] MI_C1   = 4'd2;
  localparam logic [3:0] MI_C2   = 4'd3;
  localparam logic [3:0] MI_XY   = 4'd4;
  localparam logic [3:0] MI_XX   = 4'd5;
  localparam logic [3:0] MI_YY   = 4'd6;
  localparam logic [3:0] MI_NXX  = 4'd7;
  localparam logic [3:0] MI_NYY  = 4'd8;
  localparam logic [3:0] MI_NXY  = 4'd9;
  localparam logic [3:0] MI_TERM = 4'd10;
  localparam logic [3:0] MI_CNT  = 4'd11;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [BS_W-1:0]  bs;
    logic [CK_W-1:0]  c1;
    logic [CK_W-1:0]  c2;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sx;
    logic [SUM_W-1:0] sy;
    logic [SQ_W-1:0]  sxx;
    logic [SQ_W-1:0]  syy;
    logic [SQ_W-1:0]  sxy;
  } col_t;

  typedef struct packed {
    logic is_end;
    col_t sums;
  } qent_t;

endpackage

// ----- hw/rtl/ssim_queue.sv -----
// ----------------------------------------------------------------------------
// ssim_queue
// Short queue of block sums and end-of-image marks between front and back.
// ----------------------------------------------------------------------------
module ssim_queue
  import ssim_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  qent_t wdata,
  output logic  room2,
  input  logic  rd,
  output qent_t rdata,
  output logic  valid
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  qent_t              ent_r [Q_DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [PTR_W:0]     cnt_r;

  assign valid = (cnt_r != '0);
  assign room2 = (cnt_r <= (PTR_W+1)'(Q_DEPTH - 2));
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
    end
  end

endmodule

// ----- hw/rtl/ssim_div.sv -----
// ----------------------------------------------------------------------------
// ssim_div
// Restoring divider, one quotient bit per cycle, for fractions and the mean.
// ----------------------------------------------------------------------------
module ssim_div
  import ssim_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     r_init,
  input  logic [QW-1:0]     a_init,
  input  logic [STEP_W-1:0] steps,
  input  logic [DW-1:0]     den,
  output logic              done,
  output logic [QW-1:0]     quo
);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r, steps_r;
  logic [DW-1:0]     r_r, den_r;
  logic [QW-1:0]     a_r, q_r;
  logic [DW:0]       rs;
  logic              ge;

  // The running remainder takes the next dividend bit on the right.
  assign rs   = {r_r, a_r[QW-1]};
  assign ge   = (rs >= {1'b0, den_r});
  assign done = done_r;
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      r_r     <= r_init;
      a_r     <= a_init;
      q_r     <= '0;
      den_r   <= den;
      steps_r <= steps;
      cnt_r   <= '0;
    end else if (busy_r) begin
      r_r   <= ge ? DW'(rs - {1'b0, den_r}) : DW'(rs);
      a_r   <= {a_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == steps_r - 1'b1);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == steps_r - 1'b1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/ssim_front.sv -----
// ----------------------------------------------------------------------------
// ssim_front
// Raster position tracking, per-column sums and block sum gathering.
// ----------------------------------------------------------------------------
module ssim_front
  import ssim_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             cfg_wr,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_src,
  input  logic [PIX_W-1:0] pixel_cmp,
  input  logic             q_room2,
  output logic             q_wr,
  output qent_t            q_wdata,
  output logic [DIM_W-1:0] blk_cols,
  output logic [DIM_W-1:0] blk_rows
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DW   = 5'b00010,
    F_DH   = 5'b00100,
    F_UPD  = 5'b01000,
    F_END  = 5'b10000
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic             pend_r;

  col_t             mem [MAX_WIDTH];
  col_t             rd_r, newc, acc_r, acc_nxt;

  logic [CW-1:0]    col_r, colq_r, col_blk_r;
  logic [RW-1:0]    row_r, row_blk_r;
  logic [BS_W-1:0]  col_in_r, row_in_r, col_in_inc, row_in_inc;
  logic [PIX_W-1:0] x_r, y_r;
  logic             first_r, last_r, cin0_r, blk_r, end_r;

  logic [DIM_W-1:0] bw_r, bh_r;
  logic [DIM_W-1:0] dvd_r, dvd_nxt;
  logic [BS_W:0]    rem_r, rs;
  logic             ge;
  logic [4:0]       dcnt_r;

  logic             accept, col_wrap, row_wrap, blk_end;
  logic [2*PIX_W-1:0] xx, yy, xy;

  assign accept   = push && !full;
  assign full     = (state_r != F_IDLE) || !q_room2 || pend_r;
  assign blk_cols = bw_r;
  assign blk_rows = bh_r;

  assign col_in_inc = col_in_r + 1'b1;
  assign row_in_inc = row_in_r + 1'b1;
  assign col_wrap   = ((DIM_W+1)'(col_r) + 1'b1) >= (DIM_W+1)'(cfg.w);
  assign row_wrap   = ((DIM_W+1)'(row_r) + 1'b1) >= (DIM_W+1)'(cfg.h);
  assign blk_end    = (row_in_r == cfg.bs - 1'b1) && (DIM_W'(row_blk_r) < bh_r) &&
                      (col_in_r == cfg.bs - 1'b1) && (DIM_W'(col_blk_r) < bw_r);

  // Block-count divider step: w / bs and h / bs after reset or a register write.
  assign rs      = {rem_r[BS_W-1:0], dvd_r[DIM_W-1]};
  assign ge      = (rs >= (BS_W+1)'(cfg.bs));
  assign dvd_nxt = {dvd_r[DIM_W-2:0], ge};

  assign xx = x_r * x_r;
  assign yy = y_r * y_r;
  assign xy = x_r * y_r;

  always_comb begin
    if (first_r) begin
      newc.sx  = SUM_W'(x_r);
      newc.sy  = SUM_W'(y_r);
      newc.sxx = SQ_W'(xx);
      newc.syy = SQ_W'(yy);
      newc.sxy = SQ_W'(xy);
    end else begin
      newc.sx  = rd_r.sx + SUM_W'(x_r);
      newc.sy  = rd_r.sy + SUM_W'(y_r);
      newc.sxx = rd_r.sxx + SQ_W'(xx);
      newc.syy = rd_r.syy + SQ_W'(yy);
      newc.sxy = rd_r.sxy + SQ_W'(xy);
    end
    if (cin0_r) begin
      acc_nxt = newc;
    end else begin
      acc_nxt.sx  = acc_r.sx + newc.sx;
      acc_nxt.sy  = acc_r.sy + newc.sy;
      acc_nxt.sxx = acc_r.sxx + newc.sxx;
      acc_nxt.syy = acc_r.syy + newc.syy;
      acc_nxt.sxy = acc_r.sxy + newc.sxy;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    q_wr           = 1'b0;
    q_wdata.is_end = 1'b0;
    q_wdata.sums   = acc_nxt;
    case (state_r)
      F_IDLE: begin
        if (pend_r) state_nxt = F_DW;
        else if (accept) state_nxt = F_UPD;
      end
      F_DW: begin
        if (dcnt_r == 5'(DIM_W - 1)) state_nxt = F_DH;
      end
      F_DH: begin
        if (dcnt_r == 5'(DIM_W - 1)) state_nxt = F_IDLE;
      end
      F_UPD: begin
        if (blk_r) begin
          q_wr = 1'b1;
          state_nxt = end_r ? F_END : F_IDLE;
        end else if (end_r) begin
          q_wr = 1'b1;
          q_wdata.is_end = 1'b1;
          state_nxt = F_IDLE;
        end else begin
          state_nxt = F_IDLE;
        end
      end
      F_END: begin
        q_wr = 1'b1;
        q_wdata.is_end = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == F_UPD) begin
      mem[colq_r] <= newc;
    end
    if (accept) begin
      rd_r <= mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= pixel_src;
      y_r     <= pixel_cmp;
      colq_r  <= col_r;
      first_r <= (row_in_r == '0);
      last_r  <= (row_in_r == cfg.bs - 1'b1);
      cin0_r  <= (col_in_r == '0);
      blk_r   <= blk_end;
      end_r   <= col_wrap && row_wrap;
    end
    if (state_r == F_UPD && last_r) begin
      acc_r <= acc_nxt;
    end
    if (state_r == F_IDLE) begin
      dvd_r  <= cfg.w;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (state_r == F_DW || state_r == F_DH) begin
      if (dcnt_r == 5'(DIM_W - 1)) begin
        dvd_r  <= cfg.h;
        rem_r  <= '0;
        dcnt_r <= '0;
      end else begin
        dvd_r  <= dvd_nxt;
        rem_r  <= ge ? rs - (BS_W+1)'(cfg.bs) : rs;
        dcnt_r <= dcnt_r + 1'b1;
      end
      if (dcnt_r == 5'(DIM_W - 1) && state_r == F_DW) bw_r <= dvd_nxt;
      if (dcnt_r == 5'(DIM_W - 1) && state_r == F_DH) bh_r <= dvd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      pend_r    <= 1'b1;
      col_r     <= '0;
      row_r     <= '0;
      col_in_r  <= '0;
      row_in_r  <= '0;
      col_blk_r <= '0;
      row_blk_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) pend_r <= 1'b1;
      else if (state_r == F_IDLE && pend_r) pend_r <= 1'b0;
      if (accept) begin
        if (col_wrap) begin
          col_r     <= '0;
          col_in_r  <= '0;
          col_blk_r <= '0;
          if (row_wrap) begin
            row_r     <= '0;
            row_in_r  <= '0;
            row_blk_r <= '0;
          end else begin
            row_r <= row_r + 1'b1;
            if (row_in_inc == cfg.bs) begin
              row_in_r  <= '0;
              row_blk_r <= row_blk_r + 1'b1;
            end else begin
              row_in_r <= row_in_inc;
            end
          end
        end else begin
          col_r <= col_r + 1'b1;
          if (col_in_inc == cfg.bs) begin
            col_in_r  <= '0;
            col_blk_r <= col_blk_r + 1'b1;
          end else begin
            col_in_r <= col_in_inc;
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/ssim_back.sv -----
// ----------------------------------------------------------------------------
// ssim_back
// Block SSIM term evaluation, running total and final mean with result slot.
// ----------------------------------------------------------------------------
module ssim_back
  import ssim_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic [DIM_W-1:0]  blk_cols,
  input  logic [DIM_W-1:0]  blk_rows,
  input  logic              q_valid,
  input  qent_t             q_rdata,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic [MEAN_W-1:0] ssim_mean,
  output logic              no_blocks
);

  typedef enum logic [11:0] {
    B_IDLE = 12'b000000000001,
    B_MUL  = 12'b000000000010,
    B_STO  = 12'b000000000100,
    B_EV1  = 12'b000000001000,
    B_EV2  = 12'b000000010000,
    B_DL   = 12'b000000100000,
    B_SS   = 12'b000001000000,
    B_DS   = 12'b000010000000,
    B_ACC  = 12'b000100000000,
    B_CNT  = 12'b001000000000,
    B_DM   = 12'b010000000000,
    B_OUT  = 12'b100000000000
  } bstate_t;

  bstate_t            state_r;
  logic [3:0]         idx_r;
  col_t               s_r;
  logic [31:0]        opa, opb;
  logic [63:0]        p_r;
  logic [63:0]        prod_r [MI_NUM];

  logic [DW-1:0]      a1_r, d1_r, den2_r, mag;
  logic [42:0]        vx_r, vy_r;
  logic signed [43:0] cv_r;
  logic signed [DW:0] num2_r;
  logic [30:0]        lq_r, sq_r;
  logic               neg_r;

  logic signed [TOT_W-1:0] tot_r;
  logic [TOT_W-1:0]        tot_abs;
  logic [30:0]             term_mag;
  logic [27:0]             count;

  logic [MEAN_W-1:0]  res_mean_r, out_mean_r;
  logic               res_nob_r, out_nob_r, out_v_r;

  logic               div_start, div_done;
  logic [DW-1:0]      div_r0, div_den;
  logic [QW-1:0]      div_a0, div_q;
  logic [STEP_W-1:0]  div_steps;

  assign q_rd      = (state_r == B_IDLE) && q_valid;
  assign empty     = !out_v_r;
  assign ssim_mean = out_mean_r;
  assign no_blocks = out_nob_r;

  assign mag      = num2_r[DW] ? DW'(-num2_r) : DW'(num2_r);
  assign tot_abs  = tot_r[TOT_W-1] ? TOT_W'(-tot_r) : TOT_W'(tot_r);
  assign term_mag = prod_r[MI_TERM][60:30];
  assign count    = prod_r[MI_CNT][27:0];

  always_comb begin
    case (idx_r)
      MI_N:    begin opa = 32'(cfg.bs);              opb = 32'(cfg.bs);              end
      MI_N2:   begin opa = prod_r[MI_N][31:0];       opb = prod_r[MI_N][31:0];       end
      MI_C1:   begin opa = 32'(cfg.c1);              opb = prod_r[MI_N2][31:0];      end
      MI_C2:   begin opa = 32'(cfg.c2);              opb = prod_r[MI_N2][31:0];      end
      MI_XY:   begin opa = 32'(s_r.sx);              opb = 32'(s_r.sy);              end
      MI_XX:   begin opa = 32'(s_r.sx);              opb = 32'(s_r.sx);              end
      MI_YY:   begin opa = 32'(s_r.sy);              opb = 32'(s_r.sy);              end
      MI_NXX:  begin opa = prod_r[MI_N][31:0];       opb = 32'(s_r.sxx);             end
      MI_NYY:  begin opa = prod_r[MI_N][31:0];       opb = 32'(s_r.syy);             end
      MI_NXY:  begin opa = prod_r[MI_N][31:0];       opb = 32'(s_r.sxy);             end
      MI_TERM: begin opa = 32'(lq_r);                opb = 32'(sq_r);                end
      MI_CNT:  begin opa = 32'(blk_cols);            opb = 32'(blk_rows);            end
      default: begin opa = '0;                       opb = '0;                       end
    endcase
  end

  // Divider hookup: the two fractions start from a remainder, the mean from
  // the magnitude of the total shifted in bit by bit.
  always_comb begin
    div_start = 1'b0;
    div_r0    = a1_r;
    div_a0    = '0;
    div_steps = FRAC_STEPS;
    div_den   = d1_r;
    case (state_r)
      B_EV2: begin
        div_start = !((d1_r == '0) || (a1_r >= d1_r));
      end
      B_SS: begin
        div_start = !((den2_r == '0) || (mag >= den2_r));
        div_r0    = mag;
        div_den   = den2_r;
      end
      B_CNT: begin
        div_start = (count != '0);
        div_r0    = '0;
        div_a0    = tot_abs;
        div_steps = INT_STEPS;
        div_den   = DW'(count);
      end
      default: div_start = 1'b0;
    endcase
  end

  ssim_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .r_init (div_r0),
    .a_init (div_a0),
    .steps  (div_steps),
    .den    (div_den),
    .done   (div_done),
    .quo    (div_q)
  );

  always_ff @(posedge clk) begin
    if (q_rd) s_r <= q_rdata.sums;
    if (state_r == B_MUL) p_r <= opa * opb;
    if (state_r == B_STO) prod_r[idx_r] <= p_r;
    if (state_r == B_EV1) begin
      a1_r <= (DW'(prod_r[MI_XY]) << 17) + DW'(prod_r[MI_C1]);
      d1_r <= ((DW'(prod_r[MI_XX]) + DW'(prod_r[MI_YY])) << 16) + DW'(prod_r[MI_C1]);
      vx_r <= (prod_r[MI_NXX] >= prod_r[MI_XX]) ? 43'(prod_r[MI_NXX] - prod_r[MI_XX]) : '0;
      vy_r <= (prod_r[MI_NYY] >= prod_r[MI_YY]) ? 43'(prod_r[MI_NYY] - prod_r[MI_YY]) : '0;
      cv_r <= $signed({1'b0, prod_r[MI_NXY][42:0]}) - $signed({1'b0, prod_r[MI_XY][42:0]});
    end
    if (state_r == B_EV2) begin
      num2_r <= ($signed({{(DW-43){cv_r[43]}}, cv_r}) <<< 17) +
                $signed({1'b0, prod_r[MI_C2][DW-1:0]});
      den2_r <= ((DW'(vx_r) + DW'(vy_r)) << 16) + DW'(prod_r[MI_C2]);
      if ((d1_r == '0) || (a1_r >= d1_r)) lq_r <= ONE_Q30[30:0];
    end
    if (state_r == B_DL && div_done) lq_r <= div_q[30:0];
    if (state_r == B_SS) begin
      neg_r <= num2_r[DW];
      if ((den2_r == '0) || (mag >= den2_r)) sq_r <= ONE_Q30[30:0];
    end
    if (state_r == B_DS && div_done) sq_r <= div_q[30:0];
    if (state_r == B_CNT) begin
      res_mean_r <= '0;
      res_nob_r  <= (count == '0);
    end
    if (state_r == B_DM && div_done) begin
      res_mean_r <= tot_r[TOT_W-1] ? MEAN_W'(-div_q) : MEAN_W'(div_q);
    end
    if (state_r == B_OUT && !out_v_r) begin
      out_mean_r <= res_mean_r;
      out_nob_r  <= res_nob_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= MI_N;
      tot_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (pop && out_v_r) out_v_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            idx_r   <= q_rdata.is_end ? MI_CNT : MI_N;
            state_r <= B_MUL;
          end
        end
        B_MUL: state_r <= B_STO;
        B_STO: begin
          case (idx_r)
            MI_NXY:  state_r <= B_EV1;
            MI_TERM: state_r <= B_ACC;
            MI_CNT:  state_r <= B_CNT;
            default: begin
              idx_r   <= idx_r + 1'b1;
              state_r <= B_MUL;
            end
          endcase
        end
        B_EV1: state_r <= B_EV2;
        B_EV2: state_r <= div_start ? B_DL : B_SS;
        B_DL:  if (div_done) state_r <= B_SS;
        B_SS: begin
          if (div_start) begin
            state_r <= B_DS;
          end else begin
            idx_r   <= MI_TERM;
            state_r <= B_MUL;
          end
        end
        B_DS: begin
          if (div_done) begin
            idx_r   <= MI_TERM;
            state_r <= B_MUL;
          end
        end
        B_ACC: begin
          tot_r   <= tot_r + (neg_r ? -$signed(TOT_W'(term_mag)) : $signed(TOT_W'(term_mag)));
          state_r <= B_IDLE;
        end
        B_CNT: state_r <= div_start ? B_DM : B_OUT;
        B_DM:  if (div_done) state_r <= B_OUT;
        B_OUT: begin
          if (!out_v_r) begin
            out_v_r <= 1'b1;
            tot_r   <= '0;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/block_ssim_image_quality_top.sv -----
// ----------------------------------------------------------------------------
// block_ssim_image_quality_top
// Block-mean SSIM of a source and a compressed 8-bit image, in Q1.30.
// ----------------------------------------------------------------------------
// Pixel pairs enter in raster order; each item passes through the idle and
// update states of the front end, for the read-modify-write of the
// single-port column store, and the last pixel of an image also through the
// end state when it also closes a block. Every whole block hands its sums to
// the back end through a four-entry queue; there one block term needs eleven
// products on a shared 32x32 multiplier and up to two 30-step fraction
// divisions, so full stays high while that queue is short of room. The result
// follows the last pixel after the last block term and a 56-step division of
// the total by the block count. After reset and after every register write
// the front end works out the block counts before it takes the next item.
module block_ssim_image_quality_top
  import ssim_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_BLOCK  = DEF_MAX_BLOCK
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [PIX_W-1:0]  in_pixel_src,
  input  logic [PIX_W-1:0]  in_pixel_cmp,
  output logic              empty,
  input  logic              pop,
  output logic [MEAN_W-1:0] out_ssim_mean,
  output logic              out_no_blocks,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CREG_W-1:0] width_r, height_r;
  logic [BS_W-1:0]   block_r;
  logic [CK_W-1:0]   luma_r, contrast_r;
  logic              cfg_wr;
  logic [2:0]        reg_idx;
  cfg_t              cfg;

  logic              q_wr, q_rd, q_room2, q_valid;
  qent_t             q_wdata, q_rdata;
  logic [DIM_W-1:0]  blk_cols, blk_rows;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    case (reg_idx)
      REG_WIDTH:    prdata = DATA_W'(width_r);
      REG_HEIGHT:   prdata = DATA_W'(height_r);
      REG_BLOCK:    prdata = DATA_W'(block_r);
      REG_LUMA:     prdata = DATA_W'(luma_r);
      REG_CONTRAST: prdata = DATA_W'(contrast_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      block_r    <= RST_BLOCK;
      luma_r     <= RST_LUMA;
      contrast_r <= RST_CONTRAST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:    width_r    <= pwdata[CREG_W-1:0];
        REG_HEIGHT:   height_r   <= pwdata[CREG_W-1:0];
        REG_BLOCK:    block_r    <= pwdata[BS_W-1:0];
        REG_LUMA:     luma_r     <= pwdata[CK_W-1:0];
        REG_CONTRAST: contrast_r <= pwdata[CK_W-1:0];
        default:      ;
      endcase
    end
  end

  // Out-of-range settings are used clamped to the supported range.
  always_comb begin
    if (width_r == '0) cfg.w = DIM_W'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) cfg.w = DIM_W'(MAX_WIDTH);
    else cfg.w = DIM_W'(width_r);
    if (height_r == '0) cfg.h = DIM_W'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) cfg.h = DIM_W'(MAX_HEIGHT);
    else cfg.h = DIM_W'(height_r);
    if (block_r == '0) cfg.bs = BS_W'(1);
    else if (32'(block_r) > 32'(MAX_BLOCK)) cfg.bs = BS_W'(MAX_BLOCK);
    else cfg.bs = block_r;
    cfg.c1 = luma_r;
    cfg.c2 = contrast_r;
  end

  ssim_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr),
    .push      (push),
    .full      (full),
    .pixel_src (in_pixel_src),
    .pixel_cmp (in_pixel_cmp),
    .q_room2   (q_room2),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata),
    .blk_cols  (blk_cols),
    .blk_rows  (blk_rows)
  );

  ssim_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .room2 (q_room2),
    .rd    (q_rd),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  ssim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .blk_cols  (blk_cols),
    .blk_rows  (blk_rows),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .empty     (empty),
    .pop       (pop),
    .ssim_mean (out_ssim_mean),
    .no_blocks (out_no_blocks)
  );

endmodule
